FILE: sv/uv_sphere_vertex_generator_core_assert.svh
// Assertion macros for the UV sphere vertex generator.
// Expects clk and rst_n in the scope that expands them.
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define UVS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/uvs_pkg.sv
// Shared widths, codes, types and functions of the UV sphere
// vertex generator. No dependencies.
package uvs_pkg;

  localparam int RING_W       = 10;
  localparam int SEG_W        = 11;
  localparam int SLICE_W      = 11;
  localparam int PHASE_STEP_W = 15;
  localparam int RADIUS_W     = 16;
  localparam int PHASE_W      = 16;
  localparam int POS_W        = 17;
  localparam int TEX_W        = 17;
  localparam int IDX_W        = 20;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd2;

  localparam logic [SLICE_W-1:0]      SLICE_RESET      = 11'd200;
  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RESET = 15'd328;
  localparam logic [RADIUS_W-1:0]     RADIUS_RESET     = 16'd4096;
  localparam logic [SLICE_W-1:0]      SLICE_MIN        = 11'd4;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam int POS_LIMIT = 65535;
  localparam int TEX_ONE   = 65536;

  // Divider: 12-bit divisor, 20 quotient bits, 4 steps per stage
  localparam int DIV_W     = 12;
  localparam int DIV_Q_W   = 20;
  localparam int DIV_STEPS = 4;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned HORNER_DIV [6] = '{156, 110, 72, 42, 20, 6};

  typedef struct packed {
    logic [DIV_W-1:0]   rem;
    logic [DIV_Q_W-1:0] lq;  // dividend bits still to come, quotient bits shift in
  } div_state_t;

  typedef struct packed {
    logic             has_quad;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] d;
  } corner_t;

  // Restoring division, DIV_STEPS quotient bits
  function automatic div_state_t div_steps(input div_state_t s, input logic [DIV_W-1:0] d);
    div_state_t   r;
    logic [DIV_W:0] t;
    logic         ge;
    r = s;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t     = {r.rem, r.lq[DIV_Q_W-1]};
      ge    = (t >= {1'b0, d});
      r.rem = ge ? DIV_W'(t - {1'b0, d}) : t[DIV_W-1:0];
      r.lq  = {r.lq[DIV_Q_W-2:0], ge};
    end
    return r;
  endfunction

  // Sine magnitude for quarter-wave entry idx; only ever called on constants
  function automatic logic [63:0] sine_mag(input int unsigned idx, input int unsigned shift,
                                           input int unsigned fb);
    logic [63:0] f;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] acc;
    logic [63:0] s;
    f   = 64'(idx) << shift;
    z   = (f * HALF_PI_Q30) >> 30;
    z2  = (z * z) >> 30;
    acc = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      acc = Q30_ONE - (((z2 * acc) >> 30) / 64'(HORNER_DIV[k]));
    end
    s = (z * acc) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    return (s + (64'd1 << (29 - fb))) >> (30 - fb);
  endfunction

endpackage

FILE: sv/uvs_in_if.sv
// Input channel of the UV sphere vertex generator: one grid point per transfer.
// Depends on uvs_pkg.
interface uvs_in_if;
  import uvs_pkg::*;

  logic                valid;
  logic                ready;
  logic [RING_W-1:0]   ring;
  logic [SEG_W-1:0]    segment;

  modport source(output valid, ring, segment, input ready);
  modport sink(input valid, ring, segment, output ready);
endinterface

FILE: sv/uvs_out_if.sv
// Result channel of the UV sphere vertex generator: one vertex per transfer.
// Depends on uvs_pkg.
interface uvs_out_if;
  import uvs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic                    has_quad;
  logic [IDX_W-1:0]        corner_a;
  logic [IDX_W-1:0]        corner_b;
  logic [IDX_W-1:0]        corner_c;
  logic [IDX_W-1:0]        corner_d;

  modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, has_quad,
                 corner_a, corner_b, corner_c, corner_d, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, has_quad,
               corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

FILE: sv/uv_sphere_vertex_generator_core.sv
// UV sphere vertex generator: six-stage pipeline from input transfer to result valid,
// one grid point per cycle while out_ch.ready holds (set by the stage registers;
// stages 1 to 5 each add four divider steps to their other work). Stages advance
// independently, so bubbles collapse and a stalled result holds without loss.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
// Depends on uvs_pkg, uvs_in_if, uvs_out_if and the assertion header.
`include "uv_sphere_vertex_generator_core_assert.svh"

module uv_sphere_vertex_generator_core #(
  parameter int MAX_SLICES       = 1024,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRACTION_BITS    = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  uvs_in_if.sink                         in_ch,
  uvs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uvs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import uvs_pkg::*;

  // Table geometry: a quarter wave of QD+1 entries serves the whole turn
  localparam int AB        = $clog2(SINE_TABLE_DEPTH);
  localparam int QD        = SINE_TABLE_DEPTH / 4;
  localparam int QIW       = AB - 1;
  localparam int ROM_SHIFT = 32 - AB;
  localparam int MW        = FRACTION_BITS + 1;
  localparam int SW        = FRACTION_BITS + 2;
  // Product widths: radius * trig, then * trig again
  localparam int P1W       = RADIUS_W + 1 + SW;
  localparam int P2W       = P1W + SW;
  localparam int AW        = RING_W + SLICE_W + 1;
  localparam int NSTG      = 6;

  // ---------------------------------------------------------------------------
  // Configuration registers. Slice count is stored already clamped.
  // ---------------------------------------------------------------------------
  function automatic logic [SLICE_W-1:0] clamp_slices(input logic [SLICE_W-1:0] raw);
    logic [SLICE_W-1:0] n;
    n = raw;
    if (raw < SLICE_MIN) begin
      n = SLICE_MIN;
    end else if (32'(raw) > MAX_SLICES) begin
      n = SLICE_W'(MAX_SLICES);
    end
    return n;
  endfunction

  logic [SLICE_W-1:0]      slices_r;
  logic [PHASE_STEP_W-1:0] phase_step_r;
  logic [RADIUS_W-1:0]     radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slices_r     <= clamp_slices(SLICE_RESET);
      phase_step_r <= PHASE_STEP_RESET;
      radius_r     <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLICE_COUNT: slices_r     <= clamp_slices(cfg_wdata[SLICE_W-1:0]);
        CFG_PHASE_STEP:  phase_step_r <= cfg_wdata[PHASE_STEP_W-1:0];
        CFG_RADIUS:      radius_r     <= cfg_wdata[RADIUS_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Derived values; the user keeps the registers stable whenever items are in flight
  logic [RING_W-1:0]  rings;
  logic [SLICE_W:0]   slices_p1;
  logic [DIV_W-1:0]   div_u_den;
  logic [DIV_W-1:0]   div_v_den;

  assign rings     = slices_r[SLICE_W-1:1];
  assign slices_p1 = {1'b0, slices_r} + 1'b1;
  assign div_u_den = {slices_r, 1'b0};
  assign div_v_den = {1'b0, rings, 1'b0};

  // ---------------------------------------------------------------------------
  // Stage handshake. Each stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   en;
  logic            in_fire;
  logic            out_fire;

  always_comb begin
    en[NSTG] = out_ch.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = v_r[NSTG-1];
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Quarter-wave sine table, worked out at elaboration
  // ---------------------------------------------------------------------------
  logic [MW-1:0] qtab [QD+1];

  for (genvar g = 0; g <= QD; g++) begin : g_qtab
    assign qtab[g] = MW'(sine_mag(g, ROM_SHIFT, FRACTION_BITS));
  end

  // ---------------------------------------------------------------------------
  // Stage 1: saturate indices, phase products, vertex index, divider start
  // ---------------------------------------------------------------------------
  logic [RING_W-1:0]              i_sat;
  logic [SEG_W-1:0]               j_sat;
  logic [RING_W+PHASE_STEP_W-1:0] ph_i_full;
  logic [RING_W+PHASE_STEP_W-1:0] ph_j_full;
  logic [AW-1:0]                  a_full;
  logic                           quad_nxt;
  div_state_t                     du_init;
  div_state_t                     dv_init;

  always_comb begin
    i_sat     = (in_ch.ring > rings) ? rings : in_ch.ring;
    j_sat     = (in_ch.segment > slices_r) ? slices_r : in_ch.segment;
    ph_i_full = {{PHASE_STEP_W{1'b0}}, i_sat} * {{RING_W{1'b0}}, phase_step_r};
    ph_j_full = (RING_W+PHASE_STEP_W)'(j_sat) * (RING_W+PHASE_STEP_W)'(phase_step_r);
    a_full    = AW'(i_sat) * AW'(slices_p1) + AW'(j_sat);
    quad_nxt  = (i_sat < rings) && (j_sat < slices_r);
    // u = (j*2^17 + n) / 2n, v' = (i*2^17 + rings) / 2rings
    du_init.rem = DIV_W'(j_sat >> 3);
    du_init.lq  = {j_sat[2:0], (DIV_Q_W-3)'(slices_r)};
    dv_init.rem = DIV_W'(i_sat >> 3);
    dv_init.lq  = {i_sat[2:0], (DIV_Q_W-3)'(rings)};
  end

  logic [PHASE_W-1:0] ph_i1_r;
  logic [PHASE_W-1:0] ph_j1_r;
  logic [IDX_W-1:0]   a1_r;
  logic               quad1_r;
  div_state_t         du1_r;
  div_state_t         dv1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ph_i1_r <= ph_i_full[PHASE_W-1:0];
      ph_j1_r <= ph_j_full[PHASE_W-1:0];
      a1_r    <= a_full[IDX_W-1:0];
      quad1_r <= quad_nxt;
      du1_r   <= div_steps(du_init, div_u_den);
      dv1_r   <= div_steps(dv_init, div_v_den);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: four table reads (sin i, cos i, sin j, cos j), corner indices
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]   ph_lane [4];
  logic signed [SW-1:0] trig_nxt [4];
  corner_t              corner_nxt;

  always_comb begin
    logic [AB-1:0]  k;
    logic [QIW-1:0] idx;
    logic [MW-1:0]  mag;
    ph_lane[0] = ph_i1_r;
    ph_lane[1] = ph_i1_r + QUARTER_TURN;
    ph_lane[2] = ph_j1_r;
    ph_lane[3] = ph_j1_r + QUARTER_TURN;
    for (int l = 0; l < 4; l++) begin
      k   = ph_lane[l][PHASE_W-1 -: AB];
      // mirror odd quadrants, negate the lower half-turn
      idx = k[AB-2] ? (QIW'(QD) - {1'b0, k[AB-3:0]}) : {1'b0, k[AB-3:0]};
      mag = qtab[idx];
      trig_nxt[l] = k[AB-1] ? -SW'(mag) : SW'(mag);
    end
  end

  always_comb begin
    logic [IDX_W-1:0] b;
    b = a1_r + IDX_W'(slices_p1);
    corner_nxt.has_quad = quad1_r;
    corner_nxt.a        = a1_r;
    corner_nxt.b        = quad1_r ? b : '0;
    corner_nxt.c        = quad1_r ? IDX_W'(b + 1'b1) : '0;
    corner_nxt.d        = quad1_r ? IDX_W'(a1_r + 1'b1) : '0;
  end

  logic signed [SW-1:0] trig2_r [4];
  corner_t              corner2_r;
  div_state_t           du2_r;
  div_state_t           dv2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      trig2_r   <= trig_nxt;
      corner2_r <= corner_nxt;
      du2_r     <= div_steps(du1_r, div_u_den);
      dv2_r     <= div_steps(dv1_r, div_v_den);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: radius times sin i and cos i
  // ---------------------------------------------------------------------------
  logic signed [RADIUS_W:0] radius_s;
  assign radius_s = {1'b0, radius_r};

  logic signed [P1W-1:0] rsi3_r;
  logic signed [P1W-1:0] rci3_r;
  logic signed [SW-1:0]  sj3_r;
  logic signed [SW-1:0]  cj3_r;
  corner_t               corner3_r;
  div_state_t            du3_r;
  div_state_t            dv3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rsi3_r    <= radius_s * trig2_r[0];
      rci3_r    <= radius_s * trig2_r[1];
      sj3_r     <= trig2_r[2];
      cj3_r     <= trig2_r[3];
      corner3_r <= corner2_r;
      du3_r     <= div_steps(du2_r, div_u_den);
      dv3_r     <= div_steps(dv2_r, div_v_den);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: second products for x and z, round y
  // Rounding: to nearest, ties away from zero, then clip to +-POS_LIMIT.
  // ---------------------------------------------------------------------------
  function automatic logic signed [POS_W-1:0] round_pos(input logic signed [P2W-1:0] p,
                                                        input int unsigned sh);
    logic [P2W-1:0]   mag;
    logic [POS_W-1:0] lim;
    mag = p[P2W-1] ? P2W'(-p) : P2W'(p);
    mag = (mag + (P2W'(1) << (sh - 1))) >> sh;
    lim = (mag > P2W'(POS_LIMIT)) ? POS_W'(POS_LIMIT) : mag[POS_W-1:0];
    return p[P2W-1] ? -lim : lim;
  endfunction

  logic signed [P2W-1:0]   x4_r;
  logic signed [P2W-1:0]   z4_r;
  logic signed [POS_W-1:0] y4_r;
  corner_t                 corner4_r;
  div_state_t              du4_r;
  div_state_t              dv4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x4_r      <= rsi3_r * sj3_r;
      z4_r      <= rsi3_r * cj3_r;
      y4_r      <= round_pos(P2W'(rci3_r), FRACTION_BITS);
      corner4_r <= corner3_r;
      du4_r     <= div_steps(du3_r, div_u_den);
      dv4_r     <= div_steps(dv3_r, div_v_den);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: round x and z, last divider steps
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] x5_r;
  logic signed [POS_W-1:0] z5_r;
  logic signed [POS_W-1:0] y5_r;
  corner_t                 corner5_r;
  div_state_t              du5_r;
  div_state_t              dv5_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      x5_r      <= round_pos(x4_r, 2 * FRACTION_BITS);
      z5_r      <= round_pos(z4_r, 2 * FRACTION_BITS);
      y5_r      <= y4_r;
      corner5_r <= corner4_r;
      du5_r     <= div_steps(du4_r, div_u_den);
      dv5_r     <= div_steps(dv4_r, div_v_den);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: output register; v = 1 - i/rings
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] x6_r;
  logic signed [POS_W-1:0] y6_r;
  logic signed [POS_W-1:0] z6_r;
  logic [TEX_W-1:0]        tu6_r;
  logic [TEX_W-1:0]        tv6_r;
  corner_t                 corner6_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      x6_r      <= x5_r;
      y6_r      <= y5_r;
      z6_r      <= z5_r;
      tu6_r     <= du5_r.lq[TEX_W-1:0];
      tv6_r     <= TEX_W'(DIV_Q_W'(TEX_ONE) - dv5_r.lq);
      corner6_r <= corner5_r;
    end
  end

  assign out_ch.pos_x    = x6_r;
  assign out_ch.pos_y    = y6_r;
  assign out_ch.pos_z    = z6_r;
  assign out_ch.tex_u    = tu6_r;
  assign out_ch.tex_v    = tv6_r;
  assign out_ch.has_quad = corner6_r.has_quad;
  assign out_ch.corner_a = corner6_r.a;
  assign out_ch.corner_b = corner6_r.b;
  assign out_ch.corner_c = corner6_r.c;
  assign out_ch.corner_d = corner6_r.d;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  int   occ;
  logic in_only;
  logic tex_q_ok;
  logic no_quad_out;
  logic corners_clear;

  assign occ           = $countones(v_r);
  assign in_only       = in_fire && !out_fire;
  assign tex_q_ok      = (du5_r.lq <= DIV_Q_W'(TEX_ONE)) && (dv5_r.lq <= DIV_Q_W'(TEX_ONE));
  assign no_quad_out   = out_ch.valid && !out_ch.has_quad;
  assign corners_clear = (out_ch.corner_b == '0) && (out_ch.corner_c == '0) &&
                         (out_ch.corner_d == '0);

  // An input transfer without an output transfer adds exactly one item in flight
  `UVS_ASSERT_NEXT(a_occupancy, in_only, occ == $past(occ) + 1, "item lost or duplicated")
  // Both quotients finish within one texture unit
  `UVS_ASSERT_IMPL(a_div_range, v_r[4], tex_q_ok, "texture quotient out of range")
  // Without a quad the other three corners are cleared
  `UVS_ASSERT_IMPL(a_no_quad, no_quad_out, corners_clear, "corner set without quad")

endmodule

FILE: test/uv_sphere_vertex_generator_core_checker.sv
// Scoreboard for the UV sphere vertex generator: watches both channels and the
// register port, predicts every vertex and compares it field by field.
// Depends on uvs_pkg, uvs_in_if and uvs_out_if.
module uv_sphere_vertex_generator_core_checker #(
  parameter int MAX_SLICES       = 1024,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRACTION_BITS    = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  uvs_in_if                              in_ch,
  uvs_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uvs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);
  import uvs_pkg::*;

  typedef struct {
    logic [RING_W-1:0]       ring;
    logic [SEG_W-1:0]        segment;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [TEX_W-1:0]        u;
    logic [TEX_W-1:0]        v;
    corner_t                 quad;
  } vertex_t;

  vertex_t                 pending_vertices[$];
  vertex_t                 oldest;
  logic [SLICE_W-1:0]      slices;
  logic [PHASE_STEP_W-1:0] phase_inc;
  logic [RADIUS_W-1:0]     radius_q;
  int                      sine_rom[SINE_TABLE_DEPTH];
  int                      fault_count = 0;

  assign mismatches = fault_count;

  // One entry of the full-turn sine table, Q30 Horner series folded by quadrant
  function automatic int sine_entry(input int k);
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] mag;
    t = (64'(k) << 32) / SINE_TABLE_DEPTH;
    q = (t >> 30) & 64'd3;
    f = t & (Q30_ONE - 64'd1);
    if (q[0]) f = Q30_ONE - f;
    z   = (f * HALF_PI_Q30) >> 30;
    z2  = (z * z) >> 30;
    acc = Q30_ONE;
    for (int m = 0; m < 6; m++) begin
      acc = Q30_ONE - (((z2 * acc) >> 30) / 64'(HORNER_DIV[m]));
    end
    s = (z * acc) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    mag = (s + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
    return (q >= 64'd2) ? -int'(mag) : int'(mag);
  endfunction

  initial begin
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) sine_rom[k] = sine_entry(k);
  end

  function automatic int sine_at(input logic [PHASE_W-1:0] ph);
    return sine_rom[int'((64'(ph) * SINE_TABLE_DEPTH) >> PHASE_W)];
  endfunction

  // Round to nearest with ties away from zero, then clamp to the position range
  function automatic logic signed [POS_W-1:0] round_pos(input longint p, input int sh);
    longint m;
    m = (p < 0) ? -p : p;
    m = (m + (longint'(1) << (sh - 1))) >> sh;
    if (p < 0) m = -m;
    if (m > POS_LIMIT) m = POS_LIMIT;
    if (m < -POS_LIMIT) m = -POS_LIMIT;
    return POS_W'(m);
  endfunction

  function automatic vertex_t predict_vertex(input logic [RING_W-1:0] ring,
                                             input logic [SEG_W-1:0] segment);
    vertex_t            vx;
    longint             n;
    longint             rings;
    longint             i;
    longint             j;
    longint             a;
    longint             b;
    logic [PHASE_W-1:0] ph_i;
    logic [PHASE_W-1:0] ph_j;
    int                 si;
    int                 ci;
    int                 sj;
    int                 cj;
    n = slices;
    if (n < SLICE_MIN) n = SLICE_MIN;
    if (n > MAX_SLICES) n = MAX_SLICES;
    rings = n >> 1;
    i = ring;
    j = segment;
    if (i > rings) i = rings;
    if (j > n) j = n;
    ph_i = PHASE_W'(i * phase_inc);
    ph_j = PHASE_W'(j * phase_inc);
    si = sine_at(ph_i);
    ci = sine_at(ph_i + QUARTER_TURN);
    sj = sine_at(ph_j);
    cj = sine_at(ph_j + QUARTER_TURN);
    vx.ring    = ring;
    vx.segment = segment;
    vx.x = round_pos(longint'(radius_q) * si * sj, 2 * FRACTION_BITS);
    vx.y = round_pos(longint'(radius_q) * ci, FRACTION_BITS);
    vx.z = round_pos(longint'(radius_q) * si * cj, 2 * FRACTION_BITS);
    vx.u = TEX_W'((2 * j * TEX_ONE + n) / (2 * n));
    vx.v = TEX_W'(TEX_ONE - (2 * i * TEX_ONE + rings) / (2 * rings));
    a = i * (n + 1) + j;
    b = (i + 1) * (n + 1) + j;
    vx.quad.has_quad = (i < rings) && (j < n);
    vx.quad.a = IDX_W'(a);
    vx.quad.b = vx.quad.has_quad ? IDX_W'(b) : '0;
    vx.quad.c = vx.quad.has_quad ? IDX_W'(b + 1) : '0;
    vx.quad.d = vx.quad.has_quad ? IDX_W'(a + 1) : '0;
    return vx;
  endfunction

  task automatic report_fault(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fault_count++;
  endtask

  task automatic check_field(input string name, input vertex_t want,
                             input logic signed [31:0] got, input logic signed [31:0] exp);
    if (got !== exp) begin
      report_fault($sformatf("%s at ring %0d segment %0d: got %0d, want %0d",
                             name, want.ring, want.segment, got, exp));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slices    = SLICE_RESET;
      phase_inc = PHASE_STEP_RESET;
      radius_q  = RADIUS_RESET;
      pending_vertices.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_SLICE_COUNT: slices    = cfg_wdata[SLICE_W-1:0];
          CFG_PHASE_STEP:  phase_inc = cfg_wdata[PHASE_STEP_W-1:0];
          CFG_RADIUS:      radius_q  = cfg_wdata[RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        pending_vertices.push_back(predict_vertex(in_ch.ring, in_ch.segment));
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_vertices.size() == 0) begin
          report_fault("vertex transfer with no grid point outstanding");
        end else begin
          oldest = pending_vertices.pop_front();
          check_field("pos_x", oldest, out_ch.pos_x, oldest.x);
          check_field("pos_y", oldest, out_ch.pos_y, oldest.y);
          check_field("pos_z", oldest, out_ch.pos_z, oldest.z);
          check_field("tex_u", oldest, out_ch.tex_u, oldest.u);
          check_field("tex_v", oldest, out_ch.tex_v, oldest.v);
          check_field("has_quad", oldest, out_ch.has_quad, oldest.quad.has_quad);
          check_field("corner_a", oldest, out_ch.corner_a, oldest.quad.a);
          check_field("corner_b", oldest, out_ch.corner_b, oldest.quad.b);
          check_field("corner_c", oldest, out_ch.corner_c, oldest.quad.c);
          check_field("corner_d", oldest, out_ch.corner_d, oldest.quad.d);
        end
      end
    end
    outstanding <= pending_vertices.size();
  end

endmodule

FILE: test/uv_sphere_vertex_generator_core_tb.sv
// Top of the UV sphere vertex generator testbench: clock, reset, register writes,
// grid point stimulus with random flow-control stalls, watchdog and verdict.
// Depends on uvs_pkg, uvs_in_if, uvs_out_if, the core and the checker module.
module uv_sphere_vertex_generator_core_tb;
  import uvs_pkg::*;

  localparam int MAX_SLICES       = 1024;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int FRACTION_BITS    = 12;

  // Pipeline depth from input transfer to result valid; drain a little beyond it
  localparam int PIPE_LATENCY   = 6;
  localparam int DRAIN_CYCLES   = PIPE_LATENCY + 4;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_BURST      = 18;
  // Worst case per item is a full sender gap plus a full receiver stall plus the
  // pipeline, far below this
  localparam int WATCHDOG_LIMIT = 2000;

  // Index 3 decodes to no register; writes there must leave the block unchanged
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  uvs_in_if  in_ch();
  uvs_out_if out_ch();

  int mismatches;
  int outstanding;
  bit stalls_on      = 1'b1;
  int stall_left     = 0;
  int idle_cycles    = 0;
  int points_sent    = 0;
  int settings_used  = 1;
  int slices_now;
  int rings_now;

  uv_sphere_vertex_generator_core #(
    .MAX_SLICES      (MAX_SLICES),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .FRACTION_BITS   (FRACTION_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  uv_sphere_vertex_generator_core_checker #(
    .MAX_SLICES      (MAX_SLICES),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .FRACTION_BITS   (FRACTION_BITS)
  ) vertex_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: hold ready low for random bursts while stalls are enabled,
  // otherwise keep it high so results drain at full rate
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_ch.ready  <= (stall_left == 1);
    end else if (stalls_on && $urandom_range(0, 11) == 0) begin
      stall_left    <= $urandom_range(1, MAX_BURST);
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= 1'b1;
    end
  end

  // Watchdog: count cycles without a transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog expired: no transfer for %0d cycles, %0d vertices outstanding",
               WATCHDOG_LIMIT, outstanding);
      $display("uv_sphere_vertex_generator_core_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one grid point, optionally after a gap, and hold it until the transfer.
  // Valid stays high across back-to-back points; only a gap drops it.
  task automatic push_point(input logic [RING_W-1:0] r, input logic [SEG_W-1:0] s);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.ring    <= r;
    in_ch.segment <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    points_sent++;
  endtask

  // Mostly grid points inside the current sphere, edges weighted up; the rest are
  // raw bit patterns that exercise saturation of ring and segment
  task automatic random_points(input int count);
    logic [RING_W-1:0] r;
    logic [SEG_W-1:0]  s;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        r = RING_W'($urandom);
        s = SEG_W'($urandom);
      end else begin
        r = RING_W'($urandom_range(0, rings_now));
        s = SEG_W'($urandom_range(0, slices_now));
        if ($urandom_range(0, 7) == 0) r = RING_W'(rings_now);
        if ($urandom_range(0, 7) == 0) s = SEG_W'(slices_now);
      end
      push_point(r, s);
    end
    // Drop valid in the step of the last transfer
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every vertex has come back, let the pipeline settle, then write
  // the three registers back to back (and the spare index when asked)
  task automatic set_regs(input logic [CFG_DATA_W-1:0] n_raw,
                          input logic [CFG_DATA_W-1:0] step_raw,
                          input logic [CFG_DATA_W-1:0] rad, input bit poke_spare);
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLICE_COUNT;
    cfg_wdata <= n_raw;
    @(posedge clk);
    cfg_index <= CFG_PHASE_STEP;
    cfg_wdata <= step_raw;
    @(posedge clk);
    cfg_index <= CFG_RADIUS;
    cfg_wdata <= rad;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    // Track the effective slice count only to shape the stimulus
    slices_now = n_raw[SLICE_W-1:0];
    if (slices_now < SLICE_MIN) slices_now = SLICE_MIN;
    if (slices_now > MAX_SLICES) slices_now = MAX_SLICES;
    rings_now = slices_now / 2;
    settings_used++;
  endtask

  // Random sphere: mostly an even slice count with the matching phase step,
  // sometimes an odd or out-of-range count or an unrelated step
  task automatic random_regs();
    int                    n_pick;
    logic [CFG_DATA_W-1:0] step_pick;
    n_pick = 2 * $urandom_range(2, MAX_SLICES / 2);
    if ($urandom_range(0, 5) == 0) n_pick = $urandom_range(0, 2047);
    if ($urandom_range(0, 3) == 0) step_pick = CFG_DATA_W'($urandom_range(0, 32767));
    else step_pick = (n_pick < 4) ? CFG_DATA_W'(16384) : CFG_DATA_W'(65536 / n_pick);
    set_regs(CFG_DATA_W'(n_pick), step_pick, CFG_DATA_W'($urandom_range(0, 65535)), 1'b0);
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SLICE_COUNT;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.ring    <= '0;
    in_ch.segment <= '0;
    slices_now    = SLICE_RESET;
    rings_now     = SLICE_RESET / 2;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: 200 slices, 100 rings. Poles, seam, last ring and
    // segment, saturation from oversized indices and alternating bit patterns.
    push_point(10'd0,    11'd0);
    push_point(10'd100,  11'd0);
    push_point(10'd100,  11'd200);
    push_point(10'd0,    11'd200);
    push_point(10'd99,   11'd199);
    push_point(10'd50,   11'd50);
    push_point(10'd1,    11'd1);
    push_point(10'h3FF,  11'h7FF);
    push_point(10'd512,  11'd1024);
    push_point(10'h2AA,  11'h555);
    push_point(10'h155,  11'h2AA);
    push_point(10'd25,   11'd150);
    push_point(10'd75,   11'd50);
    push_point(10'd101,  11'd201);
    random_points(30);

    // Smallest sphere with its matching step and the largest radius
    set_regs(16'd4, 16'd16384, 16'd65535, 1'b0);
    push_point(10'd0,   11'd0);
    push_point(10'd1,   11'd1);
    push_point(10'd2,   11'd4);
    push_point(10'd1,   11'd3);
    push_point(10'h3FF, 11'h7FF);
    random_points(40);

    // Largest sphere with its matching step; zero radius collapses every position
    set_regs(16'd1024, 16'd64, 16'd0, 1'b0);
    push_point(10'd512, 11'd1024);
    push_point(10'd511, 11'd1023);
    push_point(10'd0,   11'd1024);
    push_point(10'd300, 11'd17);
    random_points(40);

    // Odd slice count rounds the ring count down
    set_regs(16'd7, 16'd9362, CFG_DATA_W'($urandom), 1'b0);
    random_points(40);

    // Slice count below the minimum clamps up; step at the top of its field
    set_regs(16'd0, 16'h7FFF, 16'd1, 1'b0);
    random_points(30);

    // All-ones write masks to 2047 slices and clamps down; step unrelated to n;
    // also hit the spare register index
    set_regs(16'hFFFF, 16'd12345, 16'd40000, 1'b1);
    random_points(40);

    repeat (6) begin
      random_regs();
      random_points(45);
    end

    // Closing stretch at full rate on both sides
    stalls_on = 1'b0;
    random_regs();
    random_points(40);

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d grid points over %0d register settings, stalls on both channels",
             points_sent, settings_used);
    $display("except in the closing stretch; %0d mismatches.", mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("uv_sphere_vertex_generator_core_tb OK");
    end else begin
      $display("uv_sphere_vertex_generator_core_tb NOT OK");
    end
    $finish;
  end

endmodule
